// ----- rtl/assert_macros.svh -----
// assertion macros for the ir decoder rtl
// expects clk_i and rst_ni in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ir decoder assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ir decoder invariant failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/irdec_pkg.sv -----
// shared types, constants and helpers for the ir edge-time frame decoder
// no dependencies
package irdec_pkg;

  localparam int DURATION_SLOTS = 64;
  localparam int SLOT_AW        = $clog2(DURATION_SLOTS);
  localparam int EDGE_CNT_W     = 7;
  localparam int HALF_BITS      = 27;
  localparam int HB_W           = 5;
  localparam int CODE_W         = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_EDGES = 3'd4;

  // action codes
  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] edge_time;
  } item_t;

  typedef struct packed {
    logic              frame_valid;
    logic [CODE_W-1:0] command_code;
  } result_t;

  // half-bits that land in the command code
  function automatic logic is_code_hb(input logic [HB_W-1:0] h);
    logic hit;
    case (h)
      5'd2, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd26: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // code bit position for a half-bit, msb first from half-bit 2
  function automatic logic [2:0] code_pos(input logic [HB_W-1:0] h);
    logic [2:0] pos;
    case (h)
      5'd2:    pos = 3'd6;
      5'd16:   pos = 3'd5;
      5'd18:   pos = 3'd4;
      5'd20:   pos = 3'd3;
      5'd22:   pos = 3'd2;
      5'd24:   pos = 3'd1;
      default: pos = 3'd0;
    endcase
    return pos;
  endfunction

endpackage

// ----- rtl/ir_edge_time_frame_decoder.sv -----
// ir edge-time frame decoder: slot memory, edge counter and decode walker
// depends on irdec_pkg and assert_macros.svh
//
// usage: drive item_i with start; a transaction is taken at a rising edge
// with start high and busy low. a store transaction (action 0) writes
// edge_time into the next slot and gives no result; stores past the last
// slot are dropped. a decode transaction (action 1) gives one result on
// result_o, marked by result_valid_o for exactly one cycle.
// with too few stored edges the result (frame_valid 0) appears the cycle
// after acceptance and busy stays low. otherwise the count is cleared and
// the walker reads the slot memory from slot 1 upward and decodes at most
// slots 1..27, one read per cycle through its single read port; busy is
// high while the walker runs and low again when the result shows.
// the receiver cannot stall: results are taken in the cycle they show.
// configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i at
// any edge, with no wait. reset clears the count and the per-slot valid
// flags (unwritten slots read as zero) and loads the default thresholds.
`include "assert_macros.svh"

module ir_edge_time_frame_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  irdec_pkg::item_t                     item_i,
  output logic                                 result_valid_o,
  output irdec_pkg::result_t                   result_o,
  input  logic                                 cfg_we_i,
  input  logic [irdec_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [irdec_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import irdec_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [7:0] short_min_q, short_max_q, long_min_q, long_max_q;
  logic [EDGE_CNT_W-1:0] min_edges_q;

  logic [7:0]                slot_mem [DURATION_SLOTS];
  logic [DURATION_SLOTS-1:0] slot_vld_q;
  logic [7:0]                rd_data_q;
  logic                      rd_vld_q;

  logic                  state_q, state_d;
  logic [EDGE_CNT_W-1:0] edge_count_q, edge_count_d;
  logic [HB_W-1:0]       rd_slot_q, rd_slot_d;
  logic                  pend_q, pend_d;
  logic                  lvl_q, lvl_d;
  logic [HB_W-1:0]       hb_cnt_q, hb_cnt_d;
  logic [CODE_W-1:0]     code_q, code_d;
  logic                  res_vld_q, res_vld_d;
  result_t               res_q, res_d;

  logic               accept;
  logic               do_store;
  logic               rd_en;
  logic [HB_W-1:0]    rd_idx;
  logic [SLOT_AW-1:0] rd_addr;
  logic [SLOT_AW-1:0] wr_addr;
  logic [7:0]         dur;
  logic               is_short, is_long, hb_val;
  logic [HB_W-1:0]    hb_nxt;

  assign busy           = (state_q == ST_WALK);
  assign accept         = start && !busy;
  assign do_store       = accept && (item_i.action == ACT_STORE) &&
                          (edge_count_q < EDGE_CNT_W'(DURATION_SLOTS));
  assign wr_addr        = edge_count_q[SLOT_AW-1:0];
  assign rd_en          = (state_q == ST_WALK);
  assign rd_idx         = rd_slot_q - 5'd1;
  assign rd_addr        = SLOT_AW'(rd_idx);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= 8'd23;
      short_max_q <= 8'd36;
      long_min_q  <= 8'd51;
      long_max_q  <= 8'd64;
      min_edges_q <= 7'd13;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SHORT_MIN: short_min_q <= cfg_wdata_i;
        REG_SHORT_MAX: short_max_q <= cfg_wdata_i;
        REG_LONG_MIN:  long_min_q  <= cfg_wdata_i;
        REG_LONG_MAX:  long_max_q  <= cfg_wdata_i;
        REG_MIN_EDGES: min_edges_q <= cfg_wdata_i[EDGE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // slot memory, entry i holds slot i+1
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      slot_mem[wr_addr] <= item_i.edge_time;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (do_store) begin
        slot_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= slot_vld_q[rd_addr];
      end
    end
  end

  // classify the duration read last cycle
  always_comb begin
    dur      = rd_vld_q ? rd_data_q : 8'd0;
    is_short = (dur > short_min_q) && (dur < short_max_q);
    is_long  = !is_short && (dur > long_min_q) && (dur < long_max_q);
    hb_val   = (is_short || is_long) ? lvl_q : 1'b0;
    hb_nxt   = hb_cnt_q + 5'd1;
  end

  always_comb begin
    state_d      = state_q;
    edge_count_d = edge_count_q;
    rd_slot_d    = rd_slot_q;
    pend_d       = pend_q;
    lvl_d        = lvl_q;
    hb_cnt_d     = hb_cnt_q;
    code_d       = code_q;
    res_vld_d    = 1'b0;
    res_d        = res_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.action == ACT_STORE)) begin
          if (do_store) begin
            edge_count_d = edge_count_q + 7'd1;
          end
        end else if (accept) begin
          if (edge_count_q > min_edges_q) begin
            edge_count_d = '0;
            state_d      = ST_WALK;
            rd_slot_d    = 5'd1;
            pend_d       = 1'b0;
            hb_cnt_d     = '0;
            code_d       = '0;
          end else begin
            res_vld_d = 1'b1;
            res_d     = '0;
          end
        end
      end
      ST_WALK: begin
        // issue the next read while the previous slot is decoded
        rd_slot_d = rd_slot_q + 5'd1;
        lvl_d     = rd_slot_q[0];
        pend_d    = 1'b1;
        if (pend_q) begin
          if (is_code_hb(hb_cnt_q)) begin
            code_d[code_pos(hb_cnt_q)] = hb_val;
          end
          // second half-bit of a long duration, dropped past the last one
          if (is_long && (hb_nxt < 5'(HALF_BITS)) && is_code_hb(hb_nxt)) begin
            code_d[code_pos(hb_nxt)] = hb_val;
          end
          hb_cnt_d = is_long ? hb_cnt_q + 5'd2 : hb_nxt;
          if (hb_cnt_d >= 5'(HALF_BITS)) begin
            state_d   = ST_IDLE;
            pend_d    = 1'b0;
            res_vld_d = 1'b1;
            res_d.frame_valid  = 1'b1;
            res_d.command_code = code_d;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_count_q <= '0;
      pend_q       <= 1'b0;
      hb_cnt_q     <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_count_q <= edge_count_d;
      pend_q       <= pend_d;
      hb_cnt_q     <= hb_cnt_d;
      res_vld_q    <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_slot_d;
    lvl_q     <= lvl_d;
    code_q    <= code_d;
    res_q     <= res_d;
  end

  `ASSERT_CLK(a_result_not_busy, result_valid_o |-> !busy)
  `ASSERT_CLK(a_invalid_code_zero,
              (result_valid_o && !result_o.frame_valid) |-> (result_o.command_code == '0))
  `ASSERT_CLK(a_walk_count_clear, busy |-> (edge_count_q == '0))
  `ASSERT_CLK(a_short_frame_reply,
              (start && !busy && (item_i.action == ACT_DECODE) &&
               (edge_count_q <= min_edges_q)) |=> (result_valid_o && !result_o.frame_valid))
  `ASSERT_CLK(a_hb_bound, hb_cnt_q <= 5'(HALF_BITS + 1))

endmodule
